// ===== rtl/tsc_pkg.sv =====
// tsc_pkg: widths, constants and link types for the taylor sine/cosine pipeline
// no dependencies; imported by tsc_term_cell, tsc_out_buf, taylor_sine_cosine and the two sim files

package tsc_pkg;

    // series length
    localparam int TSC_MAX_TERMS = 10;
    localparam int NT_W          = 4;
    localparam logic [NT_W-1:0] NUM_TERMS_RST = 4'd8;

    // number formats
    localparam int ANGLE_W   = 32;
    localparam int FRAC_BITS = 28;
    localparam int OUT_W     = 48;
    localparam int MAG_W     = OUT_W - 1;

    // term update m * a split into a low and a high partial product
    localparam int LO_W     = 32;
    localparam int HI_W     = MAG_W - LO_W;
    localparam int MUL_HI_W = HI_W + ANGLE_W;
    localparam int MUL_LO_W = LO_W + ANGLE_W;

    // long division of the scaled product by the term index, one chunk per step
    localparam int DIV_CHUNK  = 17;
    localparam int DIV_CHUNKS = 3;
    localparam int SCALED_W   = DIV_CHUNK * DIV_CHUNKS;
    localparam int REM_W      = 5;
    localparam int K_W        = REM_W;
    localparam int DV_W       = REM_W + DIV_CHUNK;
    localparam int DIV_SHIFT  = DV_W + REM_W;
    localparam int RECIP_W    = DIV_SHIFT + 1;

    localparam logic [MAG_W-1:0] ONE_Q =
        {{(MAG_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    // context handed from one term cell to the next
    typedef struct packed {
        logic                     neg;
        logic [ANGLE_W-1:0]       mag_a;
        logic [MAG_W-1:0]         term;
        logic signed [OUT_W-1:0]  sin_sum;
        logic signed [OUT_W-1:0]  cos_sum;
        logic                     clip;
    } tsc_link_t;

    typedef struct packed {
        logic signed [OUT_W-1:0]  sine;
        logic signed [OUT_W-1:0]  cosine;
        logic                     clipped;
    } tsc_res_t;

endpackage

// ===== rtl/tsc_term_cell.sv =====
// tsc_term_cell: one series term, m_k = floor(m_(k-1) * a / (2^28 * k)), added to its sum
// depends on tsc_pkg; eight register stages, chained by taylor_sine_cosine

module tsc_term_cell #(
    parameter int K = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic [tsc_pkg::NT_W-1:0] n_eff,
    input  logic                    in_vld,
    input  tsc_pkg::tsc_link_t      in_link,
    output logic                    out_vld,
    output tsc_pkg::tsc_link_t      out_link
);
    import tsc_pkg::*;

    // stages: multiply, scale, then quotient/remainder per chunk, then sum
    localparam int CTX_N = 2 * DIV_CHUNKS + 1;
    localparam int PW    = DV_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(K) - 64'd1) / 64'(K));
    localparam logic [K_W-1:0]  K_VAL = K_W'(K);
    localparam logic [NT_W:0]   K_CMP = (NT_W + 1)'(K);
    localparam bit ODD = (K % 2) == 1;
    localparam bit ALT = ((K / 2) % 2) == 1;

    logic                vld_reg [CTX_N];
    tsc_link_t           ctx_reg [CTX_N];
    logic                out_vld_reg;
    tsc_link_t           out_link_reg;
    tsc_link_t           out_link_next;

    logic [MUL_HI_W-1:0] p_hi_reg;
    logic [MUL_LO_W-1:0] p_lo_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [SCALED_W-1:0] scaled_next;

    logic [DV_W-1:0]     v_reg      [DIV_CHUNKS];
    logic [SCALED_W-1:0] quo_q_reg  [DIV_CHUNKS];
    logic [SCALED_W-1:0] dvd_q_reg  [DIV_CHUNKS-1];
    logic [REM_W-1:0]    rem_reg    [DIV_CHUNKS-1];
    logic [SCALED_W-1:0] dvd_r_reg  [DIV_CHUNKS-1];
    logic [SCALED_W-1:0] quo_r_reg  [DIV_CHUNKS-1];

    logic [DV_W-1:0]     v_next     [DIV_CHUNKS];
    logic [PW-1:0]       prod       [DIV_CHUNKS];
    logic [SCALED_W-1:0] quo_next   [DIV_CHUNKS];
    logic [DV_W-1:0]     qk         [DIV_CHUNKS-1];
    logic [REM_W-1:0]    rem_next   [DIV_CHUNKS-1];

    logic [SCALED_W-1:0]      quo_fin;
    logic                     msat;
    logic [MAG_W-1:0]         mag;
    logic                     active;
    logic                     minus;
    logic signed [OUT_W:0]    term_s;
    logic signed [OUT_W-1:0]  acc;
    logic signed [OUT_W:0]    sum_wide;
    logic                     ssat;
    logic signed [OUT_W-1:0]  sum_sat;
    tsc_link_t                ctx_l;

    assign scaled_next = SCALED_W'({p_hi_reg, {(LO_W - FRAC_BITS){1'b0}}})
                       + SCALED_W'(p_lo_reg >> FRAC_BITS);

    // chunked division by the constant k, reciprocal exact for the chunk range
    always_comb begin
        v_next[0]   = {{REM_W{1'b0}}, scaled_reg[SCALED_W-1 -: DIV_CHUNK]};
        prod[0]     = PW'(v_next[0]) * PW'(RECIP);
        quo_next[0] = '0;
        quo_next[0][SCALED_W-1 -: DIV_CHUNK] = prod[0][DIV_SHIFT +: DIV_CHUNK];
        for (int j = 1; j < DIV_CHUNKS; j++) begin
            v_next[j]   = {rem_reg[j-1],
                           dvd_r_reg[j-1][SCALED_W-1-j*DIV_CHUNK -: DIV_CHUNK]};
            prod[j]     = PW'(v_next[j]) * PW'(RECIP);
            quo_next[j] = quo_r_reg[j-1];
            quo_next[j][SCALED_W-1-j*DIV_CHUNK -: DIV_CHUNK] =
                prod[j][DIV_SHIFT +: DIV_CHUNK];
        end
        for (int j = 0; j < DIV_CHUNKS - 1; j++) begin
            qk[j] = DV_W'(quo_q_reg[j][SCALED_W-1-j*DIV_CHUNK -: DIV_CHUNK])
                  * DV_W'(K_VAL);
            rem_next[j] = REM_W'(v_reg[j] - qk[j]);
        end
    end

    // saturate the term, sign it, add it into its own sum while 2 * n_eff is above k
    always_comb begin
        ctx_l    = ctx_reg[CTX_N-1];
        quo_fin  = quo_q_reg[DIV_CHUNKS-1];
        msat     = |quo_fin[SCALED_W-1:MAG_W];
        mag      = msat ? MAG_MAX : quo_fin[MAG_W-1:0];
        active   = {n_eff, 1'b0} > K_CMP;
        minus    = ALT ^ (ODD & ctx_l.neg);
        term_s   = minus ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        acc      = ODD ? ctx_l.sin_sum : ctx_l.cos_sum;
        sum_wide = $signed({acc[OUT_W-1], acc}) + term_s;
        ssat     = sum_wide[OUT_W] != sum_wide[OUT_W-1];
        if (!ssat) begin
            sum_sat = sum_wide[OUT_W-1:0];
        end else if (sum_wide[OUT_W]) begin
            sum_sat = OUT_MIN;
        end else begin
            sum_sat = OUT_MAX;
        end
        out_link_next      = ctx_l;
        out_link_next.term = mag;
        if (active) begin
            if (ODD) begin
                out_link_next.sin_sum = sum_sat;
            end else begin
                out_link_next.cos_sum = sum_sat;
            end
            out_link_next.clip = ctx_l.clip | msat | ssat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CTX_N; i++) begin
                vld_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
            for (int i = 1; i < CTX_N; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_vld_reg <= vld_reg[CTX_N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg[0] <= in_link;
            for (int i = 1; i < CTX_N; i++) begin
                ctx_reg[i] <= ctx_reg[i-1];
            end
            p_hi_reg   <= MUL_HI_W'(in_link.term[MAG_W-1:LO_W]) * MUL_HI_W'(in_link.mag_a);
            p_lo_reg   <= MUL_LO_W'(in_link.term[LO_W-1:0]) * MUL_LO_W'(in_link.mag_a);
            scaled_reg <= scaled_next;
            dvd_q_reg[0] <= scaled_reg;
            for (int j = 1; j < DIV_CHUNKS - 1; j++) begin
                dvd_q_reg[j] <= dvd_r_reg[j-1];
            end
            for (int j = 0; j < DIV_CHUNKS; j++) begin
                v_reg[j]     <= v_next[j];
                quo_q_reg[j] <= quo_next[j];
            end
            for (int j = 0; j < DIV_CHUNKS - 1; j++) begin
                rem_reg[j]   <= rem_next[j];
                dvd_r_reg[j] <= dvd_q_reg[j];
                quo_r_reg[j] <= quo_q_reg[j];
            end
            out_link_reg <= out_link_next;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_link = out_link_reg;

`ifndef SYNTHESIS
    for (genvar j = 0; j < DIV_CHUNKS - 1; j++) begin : g_rem_chk
        a_rem_below_k: assert property (@(posedge aclk) disable iff (!aresetn)
            vld_reg[3 + 2 * j] |-> rem_reg[j] < K_VAL)
            else $error("division remainder not below term index");
    end
`endif

endmodule

// ===== rtl/tsc_out_buf.sv =====
// tsc_out_buf: two-entry result buffer between the term chain and the result channel
// depends on tsc_pkg (tsc_res_t)

module tsc_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tsc_pkg::tsc_res_t push_res,
    output logic              space,
    output logic              m_valid,
    input  logic              m_ready,
    output tsc_pkg::tsc_res_t head
);
    import tsc_pkg::*;

    typedef enum logic [2:0] {
        BUF_EMPTY = 3'b001,
        BUF_ONE   = 3'b010,
        BUF_FULL  = 3'b100
    } buf_state_t;

    buf_state_t state_reg, state_next;
    tsc_res_t   head_reg, head_next;
    tsc_res_t   tail_reg, tail_next;
    logic       pop;

    assign pop     = m_valid & m_ready;
    assign m_valid = state_reg != BUF_EMPTY;
    assign space   = state_reg != BUF_FULL;
    assign head    = head_reg;

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        unique case (state_reg)
            BUF_EMPTY: begin
                if (push) begin
                    head_next  = push_res;
                    state_next = BUF_ONE;
                end
            end
            BUF_ONE: begin
                if (push && pop) begin
                    head_next = push_res;
                end else if (push) begin
                    tail_next  = push_res;
                    state_next = BUF_FULL;
                end else if (pop) begin
                    state_next = BUF_EMPTY;
                end
            end
            BUF_FULL: begin
                if (pop) begin
                    head_next  = tail_reg;
                    state_next = BUF_ONE;
                end
            end
            default: begin
                state_next = BUF_EMPTY;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BUF_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> state_reg != BUF_FULL)
        else $error("result pushed into a full buffer");

    a_tail_moves_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BUF_FULL) && pop |=> head_reg == $past(tail_reg))
        else $error("second result lost after transfer");
`endif

endmodule

// ===== rtl/taylor_sine_cosine.sv =====
// taylor_sine_cosine: truncated maclaurin sine and cosine of a Q3.28 angle, Q19.28 results
// depends on tsc_pkg, tsc_term_cell, tsc_out_buf
//
//  channel  dir  ports                                           transfer when
//  s_       in   s_valid s_ready s_angle                         s_valid & s_ready
//  m_       out  m_valid m_ready m_sine_value m_cosine_value
//                m_clipped                                       m_valid & m_ready
//  cfg_     in   cfg_valid cfg_ready cfg_num_terms               cfg_valid & cfg_ready
//
//  one angle per cycle while s_ready is high; an angle passes the front register, then the
//  chain of term cells, each eight register stages deep, then the result buffer
//  reset (synchronous, aresetn low) empties the chain and sets num_terms to 8
//  results collect in a two-entry buffer; s_ready drops only when both entries are held,
//  and then the whole chain holds until a result transfer frees an entry
//  cfg_ready is always high; num_terms is used live, so write it only when no angle is in flight

module taylor_sine_cosine #(
    parameter int MAX_TERMS = tsc_pkg::TSC_MAX_TERMS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // angle channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [tsc_pkg::ANGLE_W-1:0] s_angle,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [tsc_pkg::OUT_W-1:0]  m_sine_value,
    output logic signed [tsc_pkg::OUT_W-1:0]  m_cosine_value,
    output logic                              m_clipped,
    // num_terms write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsc_pkg::NT_W-1:0]          cfg_num_terms
);
    import tsc_pkg::*;

    // one cell per term after the first cosine term (which is the constant 1.0)
    localparam int NCELLS = 2 * MAX_TERMS - 1;

    logic [NT_W-1:0]    num_terms_reg;
    logic [NT_W-1:0]    n_eff;
    logic               en;
    logic [ANGLE_W-1:0] angle_u;

    // front stage: |x|, sign, first term and the k = 0 cosine term
    logic               front_vld_reg;
    tsc_link_t          front_reg;
    tsc_link_t          front_next;

    logic               link_vld [NCELLS+1];
    tsc_link_t          link_dat [NCELLS+1];

    tsc_res_t           fin_res;
    tsc_res_t           head;
    logic               space;

    // register write, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_terms_reg <= NUM_TERMS_RST;
        end else if (cfg_valid) begin
            num_terms_reg <= cfg_num_terms;
        end
    end

    // term count above the chain length is cut to the chain length
    assign n_eff = (num_terms_reg > NT_W'(MAX_TERMS)) ? NT_W'(MAX_TERMS) : num_terms_reg;

    // the whole chain moves while the result buffer has a free entry
    assign en      = space;
    assign s_ready = en;

    // two's complement magnitude; the most negative angle gives 2^31 unsigned
    assign angle_u = s_angle;

    always_comb begin
        front_next.neg     = angle_u[ANGLE_W-1];
        front_next.mag_a   = angle_u[ANGLE_W-1] ? (~angle_u + ANGLE_W'(1)) : angle_u;
        front_next.term    = ONE_Q;
        front_next.sin_sum = '0;
        front_next.cos_sum = (n_eff != '0) ? $signed(OUT_W'(ONE_Q)) : '0;
        front_next.clip    = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_vld_reg <= 1'b0;
        end else if (en) begin
            front_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            front_reg <= front_next;
        end
    end

    assign link_vld[0] = front_vld_reg;
    assign link_dat[0] = front_reg;

    // term cells k = 1 .. 2 * MAX_TERMS - 1, odd k feed sine, even k feed cosine
    for (genvar c = 0; c < NCELLS; c++) begin : g_cell
        tsc_term_cell #(
            .K (c + 1)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .n_eff    (n_eff),
            .in_vld   (link_vld[c]),
            .in_link  (link_dat[c]),
            .out_vld  (link_vld[c+1]),
            .out_link (link_dat[c+1])
        );
    end

    always_comb begin
        fin_res.sine    = link_dat[NCELLS].sin_sum;
        fin_res.cosine  = link_dat[NCELLS].cos_sum;
        fin_res.clipped = link_dat[NCELLS].clip;
    end

    // output register pair, parts the result side from the chain
    tsc_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (en & link_vld[NCELLS]),
        .push_res (fin_res),
        .space    (space),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .head     (head)
    );

    assign m_sine_value   = head.sine;
    assign m_cosine_value = head.cosine;
    assign m_clipped      = head.clipped;

`ifndef SYNTHESIS
    a_stall_only_when_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result waiting");
`endif

endmodule

// ===== sim/tsc_result_checker.sv =====
// tsc_result_checker: predicts sine/cosine series results for each accepted angle and
// compares them with the result channel; depends on tsc_pkg only

module tsc_result_checker
    import tsc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic signed [ANGLE_W-1:0] s_angle,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [OUT_W-1:0]   m_sine_value,
    input  logic signed [OUT_W-1:0]   m_cosine_value,
    input  logic                      m_clipped,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [NT_W-1:0]           cfg_num_terms,
    output int                        in_flight,
    output int                        miscompares,
    output int                        results_seen
);

    localparam longint SUM_MAX = longint'(OUT_MAX);
    localparam longint SUM_MIN = longint'(OUT_MIN);
    localparam logic [63:0] TERM_MAX = {{(64 - MAG_W){1'b0}}, MAG_MAX};

    logic [NT_W-1:0] terms_now;
    tsc_res_t        sincos_due [$];

    function automatic longint clamp_sum(input longint v, inout logic hit);
        if (v > SUM_MAX) begin
            hit = 1'b1;
            return SUM_MAX;
        end
        if (v < SUM_MIN) begin
            hit = 1'b1;
            return SUM_MIN;
        end
        return v;
    endfunction

    // term k is built from term k-1 as floor(m * |x| / (2^28 * k)), truncating each step
    function automatic tsc_res_t maclaurin_sincos(input logic signed [ANGLE_W-1:0] x,
                                                  input logic [NT_W-1:0] nt);
        logic [ANGLE_W-1:0] ux;
        logic [ANGLE_W-1:0] ux_neg;
        logic               neg;
        logic [63:0]        a;
        logic [63:0]        mag;
        logic [63:0]        hi;
        logic [63:0]        lo;
        logic [63:0]        scaled;
        logic [63:0]        q;
        logic [63:0]        kdiv;
        longint             s_acc;
        longint             c_acc;
        longint             t;
        logic               clip;
        logic               minus;
        int                 n;
        tsc_res_t           r;
        ux     = x;
        neg    = ux[ANGLE_W-1];
        ux_neg = ~ux + ANGLE_W'(1);
        // most negative angle negates to 2^31, which the 32-bit form holds unsigned
        a      = neg ? {32'd0, ux_neg} : {32'd0, ux};
        n      = (nt > TSC_MAX_TERMS) ? TSC_MAX_TERMS : int'(nt);
        mag    = 64'd1 << FRAC_BITS;
        s_acc  = 0;
        c_acc  = 0;
        clip   = 1'b0;
        for (int k = 0; k < 2 * n; k++) begin
            if (k > 0) begin
                hi     = mag >> 32;
                lo     = mag & 64'h0000_0000_FFFF_FFFF;
                scaled = ((hi * a) << (32 - FRAC_BITS)) + ((lo * a) >> FRAC_BITS);
                kdiv   = 64'(k);
                q      = scaled / kdiv;
                if (q > TERM_MAX) begin
                    q    = TERM_MAX;
                    clip = 1'b1;
                end
                mag = q;
            end
            minus = k[1];
            if (k[0]) begin
                if (neg) minus = !minus;
                t     = minus ? -$signed(mag) : $signed(mag);
                s_acc = clamp_sum(s_acc + t, clip);
            end else begin
                t     = minus ? -$signed(mag) : $signed(mag);
                c_acc = clamp_sum(c_acc + t, clip);
            end
        end
        r.sine    = s_acc[OUT_W-1:0];
        r.cosine  = c_acc[OUT_W-1:0];
        r.clipped = clip;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        tsc_res_t due;
        if (!aresetn) begin
            sincos_due.delete();
            terms_now    <= NUM_TERMS_RST;
            in_flight    <= 0;
            miscompares  <= 0;
            results_seen <= 0;
        end else begin
            if (cfg_valid && cfg_ready) terms_now <= cfg_num_terms;
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (sincos_due.size() == 0) begin
                    if (miscompares < 10)
                        $display("result %0d arrived with nothing pending: sine %h cosine %h",
                                 results_seen, m_sine_value, m_cosine_value);
                    miscompares <= miscompares + 1;
                end else begin
                    due = sincos_due.pop_front();
                    if (due.sine !== m_sine_value || due.cosine !== m_cosine_value ||
                        due.clipped !== m_clipped) begin
                        if (miscompares < 10)
                            $display({"result %0d: sine exp %h got %h, ",
                                      "cosine exp %h got %h, clipped exp %0d got %0d"},
                                     results_seen, due.sine, m_sine_value, due.cosine,
                                     m_cosine_value, due.clipped, m_clipped);
                        miscompares <= miscompares + 1;
                    end
                end
            end
            if (s_valid && s_ready) sincos_due.push_back(maclaurin_sincos(s_angle, terms_now));
            in_flight <= sincos_due.size();
        end
    end

endmodule

// ===== sim/taylor_sine_cosine_test.sv =====
// taylor_sine_cosine_test: stimulus and verdict for the taylor sine/cosine pipeline
// depends on tsc_pkg, taylor_sine_cosine and tsc_result_checker

module taylor_sine_cosine_test;
    import tsc_pkg::*;

    // gap patterns applied per phase
    typedef enum int {GAPS_NONE, GAPS_SEND, GAPS_RECV, GAPS_BOTH} gap_mode_t;

    localparam int N_PHASES    = 11;
    localparam int HOLD_PHASE  = 5;     // phase with the long receiver hold-off
    localparam int HOLD_CYCLES = 600;   // well past the pipeline depth plus buffer
    localparam int QUIET_LIMIT = 5000;  // cycles with no transfer before giving up
    localparam int DRAIN_WAIT  = 200;   // extra watch time after the drain, for stray results
    localparam int N_CORNERS   = 20;
    localparam logic signed [ANGLE_W-1:0] PI_Q = 32'sd843314857;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [ANGLE_W-1:0] s_angle;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [OUT_W-1:0]   m_sine_value;
    logic signed [OUT_W-1:0]   m_cosine_value;
    logic                      m_clipped;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [NT_W-1:0]           cfg_num_terms;

    int in_flight;
    int miscompares;
    int results_seen;

    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_req;
    int   angles_sent;
    int   quiet_cycles;

    logic signed [ANGLE_W-1:0] corner_angles [0:N_CORNERS-1];

    taylor_sine_cosine DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_angle        (s_angle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sine_value   (m_sine_value),
        .m_cosine_value (m_cosine_value),
        .m_clipped      (m_clipped),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_num_terms  (cfg_num_terms)
    );

    // scoreboard sits beside the block and only watches the three channels
    tsc_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_angle        (s_angle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sine_value   (m_sine_value),
        .m_cosine_value (m_cosine_value),
        .m_clipped      (m_clipped),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_num_terms  (cfg_num_terms),
        .in_flight      (in_flight),
        .miscompares    (miscompares),
        .results_seen   (results_seen)
    );

    // clock, period 4
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // angle mix: mostly full range so every bit toggles, plus small angles,
    // angles near plus or minus pi, the two ends of the range and values near zero
    function automatic logic signed [ANGLE_W-1:0] random_angle();
        logic [ANGLE_W-1:0] r;
        logic signed [ANGLE_W-1:0] near_pi;
        r = $urandom;
        near_pi = PI_Q + $signed($urandom_range(2000)) - 32'sd1000;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return r;
            5, 6:          return $signed(r) >>> 3;
            7:             return r[0] ? -near_pi : near_pi;
            8:             return r[0] ? 32'sh7FFF_FFFF - ANGLE_W'(r[7:0])
                                       : 32'sh8000_0000 + ANGLE_W'(r[7:0]);
            default:       return $signed(r) >>> 20;
        endcase
    endfunction

    // one angle transfer; random idle cycles first, valid held until accepted.
    // valid is left high on return so back-to-back transfers need no toggle
    task automatic send_angle(input logic signed [ANGLE_W-1:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_angle <= x;
        do @(posedge aclk); while (!s_ready);
        angles_sent++;
    endtask

    // num_terms write transfer, only issued with the pipeline empty
    task automatic write_num_terms(input logic [NT_W-1:0] v);
        cfg_valid     <= 1'b1;
        cfg_num_terms <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // sender pause until every predicted result has been taken
    task automatic wait_drained();
        do @(posedge aclk); while (in_flight != 0);
    endtask

    // result side: random stalls at the current rate, or one long hold-off
    // counted here while the sender keeps pushing, so the chain fills and s_ready drops
    initial begin : result_sink
        logic hold_taken;
        hold_taken = 1'b0;
        m_ready    = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
                @(posedge aclk);
            end
        end
    end

    // watchdog: any transfer on any channel restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, in_flight);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int        terms;
        int        items;
        gap_mode_t gaps;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_angle       = '0;
        cfg_valid     = 1'b0;
        cfg_num_terms = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b0;
        angles_sent   = 0;
        // zero, one lsb, range ends, +-1.0, +-pi, +-pi/2, +-2pi, +-4.0, bit patterns
        corner_angles = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                          32'sh1000_0000, -32'sh1000_0000, PI_Q, -PI_Q,
                          32'sd421657428, -32'sd421657428, 32'sd1686629713,
                          -32'sd1686629713, 32'sh4000_0000, -32'sh4000_0000,
                          32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0100,
                          32'sh3000_0000, 32'sh9000_0000};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner angles back to back with the reset term count
        for (int i = 0; i < N_CORNERS; i++) send_angle(corner_angles[i]);
        s_valid <= 1'b0;

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            case (p)
                0:       begin terms = 0;  gaps = GAPS_NONE; items = 60;  end
                1:       begin terms = 10; gaps = GAPS_NONE; items = 110; end
                2:       begin terms = 1;  gaps = GAPS_SEND; items = 100; end
                3:       begin terms = 15; gaps = GAPS_RECV; items = 100; end
                4:       begin terms = 5;  gaps = GAPS_BOTH; items = 100; end
                5:       begin terms = 10; gaps = GAPS_NONE; items = 300; end
                6:       begin terms = 3;  gaps = GAPS_SEND; items = 100; end
                7:       begin terms = 8;  gaps = GAPS_RECV; items = 100; end
                8:       begin terms = 2;  gaps = GAPS_BOTH; items = 100; end
                9:       begin terms = 12; gaps = GAPS_SEND; items = 80;  end
                default: begin
                    terms = $urandom_range(15);
                    gaps  = gap_mode_t'($urandom_range(3));
                    items = 130;
                end
            endcase
            write_num_terms(terms[NT_W-1:0]);
            send_idle_pct <= (gaps == GAPS_SEND) ? 62 : (gaps == GAPS_BOTH) ? 16 : 0;
            recv_idle_pct <= (gaps == GAPS_RECV) ? 62 : (gaps == GAPS_BOTH) ? 16 : 0;
            if (p == HOLD_PHASE) hold_req <= 1'b1;
            repeat (items) send_angle(random_angle());
            s_valid <= 1'b0;
        end

        // let the pipeline empty, then watch a little longer for stray results
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("sent %0d angles over %0d term settings, %0d results compared",
                 angles_sent, N_PHASES + 1, results_seen);
        $display("%0d miscompares, %0d results still outstanding", miscompares, in_flight);
        if (miscompares == 0 && in_flight == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tsc_pkg.sv
rtl/tsc_term_cell.sv
rtl/tsc_out_buf.sv
rtl/taylor_sine_cosine.sv
sim/tsc_result_checker.sv
sim/taylor_sine_cosine_test.sv
